// File: design/tlfcl_pkg.sv
package tlfcl_pkg;

    localparam int L1_ENTRIES = 32;
    localparam int L2_ENTRIES = 128;
    localparam int L3_ENTRIES = 512;
    localparam int TAG_BITS   = 32;

    localparam int BLOCK_TAG_BITS = 32;
    localparam int LAT_BITS       = 10;
    localparam int COUNT_BITS     = 16;
    localparam int LEVEL_BITS     = 2;
    localparam int CFG_IDX_BITS   = 8;

    // address and occupancy widths per level
    localparam int L1_AW = (L1_ENTRIES > 1) ? $clog2(L1_ENTRIES) : 1;
    localparam int L2_AW = (L2_ENTRIES > 1) ? $clog2(L2_ENTRIES) : 1;
    localparam int L3_AW = (L3_ENTRIES > 1) ? $clog2(L3_ENTRIES) : 1;
    localparam int L1_CW = $clog2(L1_ENTRIES + 1);
    localparam int L2_CW = $clog2(L2_ENTRIES + 1);
    localparam int L3_CW = $clog2(L3_ENTRIES + 1);
    localparam int SCAN_W12 = (L1_CW > L2_CW) ? L1_CW : L2_CW;
    localparam int SCAN_W   = (SCAN_W12 > L3_CW) ? SCAN_W12 : L3_CW;

    typedef logic [TAG_BITS-1:0]   t_tag;
    typedef logic [L1_AW-1:0]      t_addr1;
    typedef logic [L2_AW-1:0]      t_addr2;
    typedef logic [L3_AW-1:0]      t_addr3;
    typedef logic [L1_CW-1:0]      t_cnt1;
    typedef logic [L2_CW-1:0]      t_cnt2;
    typedef logic [L3_CW-1:0]      t_cnt3;
    typedef logic [SCAN_W-1:0]     t_scan;
    typedef logic [LAT_BITS-1:0]   t_lat;
    typedef logic [COUNT_BITS-1:0] t_count;

    localparam t_cnt1  L1_FULL = t_cnt1'(L1_ENTRIES);
    localparam t_cnt2  L2_FULL = t_cnt2'(L2_ENTRIES);
    localparam t_cnt3  L3_FULL = t_cnt3'(L3_ENTRIES);
    localparam t_addr1 L1_LAST = t_addr1'(L1_ENTRIES - 1);
    localparam t_addr2 L2_LAST = t_addr2'(L2_ENTRIES - 1);
    localparam t_addr3 L3_LAST = t_addr3'(L3_ENTRIES - 1);

    localparam t_lat LAT1_RST = t_lat'(4);
    localparam t_lat LAT2_RST = t_lat'(12);
    localparam t_lat LAT3_RST = t_lat'(40);
    localparam t_lat LATM_RST = t_lat'(200);

    localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_LAT  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_SECOND_LAT = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_THIRD_LAT  = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_MEMORY_LAT = CFG_IDX_BITS'(3);

    typedef enum logic [LEVEL_BITS-1:0] {
        LVL_FIRST  = 2'd0,
        LVL_SECOND = 2'd1,
        LVL_THIRD  = 2'd2,
        LVL_MEMORY = 2'd3
    } t_level;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FILL,
        ST_DONE
    } t_state;

endpackage

// File: design/tlfcl_ram.sv
module tlfcl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/three_level_fifo_cache_lookup.sv
// Three-level fully associative tag lookup with FIFO replacement per level.
// Each tag level lives in its own single-port-read RAM; a transaction scans
// the first level, then the second, then the third, comparing one stored tag
// per cycle against the incoming tag. After the scan the FILL state writes the
// tag into every level that missed, the DONE state hands the result to the
// output register once that is free, and the block is ready again. One
// transaction is in flight at a time; a finished result may wait in the
// output register while the next transaction is accepted. Latency registers
// are written through the config port (index 0..3, other indexes ignored)
// and are always ready.
module three_level_fifo_cache_lookup (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [tlfcl_pkg::BLOCK_TAG_BITS-1:0] i_block_tag,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [tlfcl_pkg::LEVEL_BITS-1:0]     o_hit_level,
    output logic [tlfcl_pkg::LAT_BITS-1:0]       o_access_latency,
    output logic [tlfcl_pkg::COUNT_BITS-1:0]     o_memory_fetch_count,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tlfcl_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [tlfcl_pkg::LAT_BITS-1:0]       i_cfg_data
);

    tlfcl_pkg::t_state r_state, n_state;
    tlfcl_pkg::t_tag   r_tag, n_tag;
    tlfcl_pkg::t_level r_lvl, n_lvl;
    tlfcl_pkg::t_scan  r_idx, n_idx;
    logic              r_pend, n_pend;
    tlfcl_pkg::t_cnt1  r_fill1, n_fill1;
    tlfcl_pkg::t_cnt2  r_fill2, n_fill2;
    tlfcl_pkg::t_cnt3  r_fill3, n_fill3;
    tlfcl_pkg::t_addr1 r_old1, n_old1;
    tlfcl_pkg::t_addr2 r_old2, n_old2;
    tlfcl_pkg::t_addr3 r_old3, n_old3;
    tlfcl_pkg::t_count r_count, n_count;
    tlfcl_pkg::t_lat   r_lat1, r_lat2, r_lat3, r_latm;
    logic              r_out_valid, n_out_valid;
    tlfcl_pkg::t_level r_out_level, n_out_level;
    tlfcl_pkg::t_lat   r_out_lat, n_out_lat;
    tlfcl_pkg::t_count r_out_count, n_out_count;

    tlfcl_pkg::t_tag   rd_data1, rd_data2, rd_data3, rd_data;
    tlfcl_pkg::t_scan  cur_fill;
    logic              rd_hit;
    logic              scan_rd;
    logic              wr_en1, wr_en2, wr_en3;
    tlfcl_pkg::t_addr1 wr_addr1;
    tlfcl_pkg::t_addr2 wr_addr2;
    tlfcl_pkg::t_addr3 wr_addr3;
    tlfcl_pkg::t_lat   sel_lat;

    tlfcl_ram #(.WIDTH(tlfcl_pkg::TAG_BITS), .DEPTH(tlfcl_pkg::L1_ENTRIES)) u_l1_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en1),
        .i_wr_addr (wr_addr1),
        .i_wr_data (r_tag),
        .i_rd_en   (scan_rd && (r_lvl == tlfcl_pkg::LVL_FIRST)),
        .i_rd_addr (r_idx[tlfcl_pkg::L1_AW-1:0]),
        .o_rd_data (rd_data1)
    );

    tlfcl_ram #(.WIDTH(tlfcl_pkg::TAG_BITS), .DEPTH(tlfcl_pkg::L2_ENTRIES)) u_l2_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en2),
        .i_wr_addr (wr_addr2),
        .i_wr_data (r_tag),
        .i_rd_en   (scan_rd && (r_lvl == tlfcl_pkg::LVL_SECOND)),
        .i_rd_addr (r_idx[tlfcl_pkg::L2_AW-1:0]),
        .o_rd_data (rd_data2)
    );

    tlfcl_ram #(.WIDTH(tlfcl_pkg::TAG_BITS), .DEPTH(tlfcl_pkg::L3_ENTRIES)) u_l3_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en3),
        .i_wr_addr (wr_addr3),
        .i_wr_data (r_tag),
        .i_rd_en   (scan_rd && (r_lvl == tlfcl_pkg::LVL_THIRD)),
        .i_rd_addr (r_idx[tlfcl_pkg::L3_AW-1:0]),
        .o_rd_data (rd_data3)
    );

    assign o_in_stall           = (r_state != tlfcl_pkg::ST_IDLE);
    assign o_cfg_ready          = 1'b1;
    assign o_out_valid          = r_out_valid;
    assign o_hit_level          = r_out_level;
    assign o_access_latency     = r_out_lat;
    assign o_memory_fetch_count = r_out_count;

    // level-indexed views of the scan
    always_comb begin
        case (r_lvl)
            tlfcl_pkg::LVL_FIRST: begin
                cur_fill = tlfcl_pkg::t_scan'(r_fill1);
                rd_data  = rd_data1;
                sel_lat  = r_lat1;
            end
            tlfcl_pkg::LVL_SECOND: begin
                cur_fill = tlfcl_pkg::t_scan'(r_fill2);
                rd_data  = rd_data2;
                sel_lat  = r_lat2;
            end
            tlfcl_pkg::LVL_THIRD: begin
                cur_fill = tlfcl_pkg::t_scan'(r_fill3);
                rd_data  = rd_data3;
                sel_lat  = r_lat3;
            end
            default: begin
                cur_fill = '0;
                rd_data  = rd_data3;
                sel_lat  = r_latm;
            end
        endcase
    end

    // compare result of the read issued last cycle
    assign rd_hit  = r_pend && (rd_data == r_tag);
    assign scan_rd = (r_state == tlfcl_pkg::ST_SCAN) && !rd_hit && (r_idx < cur_fill);

    // fill into every level faster than the one that served the access;
    // those levels just missed, so no duplicate check is needed
    assign wr_en1   = (r_state == tlfcl_pkg::ST_FILL) && (r_lvl != tlfcl_pkg::LVL_FIRST);
    assign wr_en2   = (r_state == tlfcl_pkg::ST_FILL) && ((r_lvl == tlfcl_pkg::LVL_THIRD) ||
                                                         (r_lvl == tlfcl_pkg::LVL_MEMORY));
    assign wr_en3   = (r_state == tlfcl_pkg::ST_FILL) && (r_lvl == tlfcl_pkg::LVL_MEMORY);
    assign wr_addr1 = (r_fill1 != tlfcl_pkg::L1_FULL) ? r_fill1[tlfcl_pkg::L1_AW-1:0] : r_old1;
    assign wr_addr2 = (r_fill2 != tlfcl_pkg::L2_FULL) ? r_fill2[tlfcl_pkg::L2_AW-1:0] : r_old2;
    assign wr_addr3 = (r_fill3 != tlfcl_pkg::L3_FULL) ? r_fill3[tlfcl_pkg::L3_AW-1:0] : r_old3;

    always_comb begin
        n_state     = r_state;
        n_tag       = r_tag;
        n_lvl       = r_lvl;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_fill1     = r_fill1;
        n_fill2     = r_fill2;
        n_fill3     = r_fill3;
        n_old1      = r_old1;
        n_old2      = r_old2;
        n_old3      = r_old3;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_level = r_out_level;
        n_out_lat   = r_out_lat;
        n_out_count = r_out_count;

        case (r_state)
            tlfcl_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_tag   = tlfcl_pkg::t_tag'(i_block_tag);
                    n_lvl   = tlfcl_pkg::LVL_FIRST;
                    n_idx   = '0;
                    n_state = tlfcl_pkg::ST_SCAN;
                end
            end
            tlfcl_pkg::ST_SCAN: begin
                if (rd_hit) begin
                    n_state = tlfcl_pkg::ST_FILL;
                end else if (r_idx < cur_fill) begin
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    // level exhausted with no match
                    n_idx = '0;
                    case (r_lvl)
                        tlfcl_pkg::LVL_FIRST:  n_lvl = tlfcl_pkg::LVL_SECOND;
                        tlfcl_pkg::LVL_SECOND: n_lvl = tlfcl_pkg::LVL_THIRD;
                        default: begin
                            n_lvl   = tlfcl_pkg::LVL_MEMORY;
                            n_state = tlfcl_pkg::ST_FILL;
                        end
                    endcase
                end
            end
            tlfcl_pkg::ST_FILL: begin
                if (wr_en1) begin
                    if (r_fill1 != tlfcl_pkg::L1_FULL) begin
                        n_fill1 = r_fill1 + 1'b1;
                    end else begin
                        n_old1 = (r_old1 == tlfcl_pkg::L1_LAST) ? '0 : r_old1 + 1'b1;
                    end
                end
                if (wr_en2) begin
                    if (r_fill2 != tlfcl_pkg::L2_FULL) begin
                        n_fill2 = r_fill2 + 1'b1;
                    end else begin
                        n_old2 = (r_old2 == tlfcl_pkg::L2_LAST) ? '0 : r_old2 + 1'b1;
                    end
                end
                if (wr_en3) begin
                    if (r_fill3 != tlfcl_pkg::L3_FULL) begin
                        n_fill3 = r_fill3 + 1'b1;
                    end else begin
                        n_old3 = (r_old3 == tlfcl_pkg::L3_LAST) ? '0 : r_old3 + 1'b1;
                    end
                    if (r_count != '1) begin
                        n_count = r_count + 1'b1;
                    end
                end
                n_state = tlfcl_pkg::ST_DONE;
            end
            tlfcl_pkg::ST_DONE: begin
                // wait here while the previous result is still held
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_level = r_lvl;
                    n_out_lat   = sel_lat;
                    n_out_count = r_count;
                    n_state     = tlfcl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tlfcl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlfcl_pkg::ST_IDLE;
            r_pend      <= 1'b0;
            r_fill1     <= '0;
            r_fill2     <= '0;
            r_fill3     <= '0;
            r_old1      <= '0;
            r_old2      <= '0;
            r_old3      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_fill1     <= n_fill1;
            r_fill2     <= n_fill2;
            r_fill3     <= n_fill3;
            r_old1      <= n_old1;
            r_old2      <= n_old2;
            r_old3      <= n_old3;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag       <= n_tag;
        r_lvl       <= n_lvl;
        r_idx       <= n_idx;
        r_out_level <= n_out_level;
        r_out_lat   <= n_out_lat;
        r_out_count <= n_out_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat1 <= tlfcl_pkg::LAT1_RST;
            r_lat2 <= tlfcl_pkg::LAT2_RST;
            r_lat3 <= tlfcl_pkg::LAT3_RST;
            r_latm <= tlfcl_pkg::LATM_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tlfcl_pkg::REG_FIRST_LAT:  r_lat1 <= i_cfg_data;
                tlfcl_pkg::REG_SECOND_LAT: r_lat2 <= i_cfg_data;
                tlfcl_pkg::REG_THIRD_LAT:  r_lat3 <= i_cfg_data;
                tlfcl_pkg::REG_MEMORY_LAT: r_latm <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule
